// File: design/positional_list_store_assert.svh
// ---------------------------------------------------------------------------
// positional_list_store assertion macros
// shared property forms for the checker of the list store
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define PLS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define PLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pls_pkg.sv
// ---------------------------------------------------------------------------
// pls_pkg
// shared codes, types and sizes of the positional list store
// ---------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int CAPACITY_MAX     = 64;
  // wide enough to index any cell of the largest list
  localparam int IDX_W            = $clog2(CAPACITY_MAX + 1);

  localparam int ACTION_W  = 3;
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 8;
  localparam int STATUS_W  = 3;
  localparam int LENGTH_W  = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_END   = 3'd1,
    ACT_INS_POS   = 3'd2,
    ACT_DEL_FRONT = 3'd3,
    ACT_DEL_END   = 3'd4,
    ACT_DEL_POS   = 3'd5,
    ACT_DUMP      = 3'd6
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOPOS    = 3'd3,
    ST_FULL     = 3'd4,
    ST_APPENDED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_ROTATE = 2'd3
  } cmd_kind_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cmd_kind_t        kind;
    logic [IDX_W-1:0] idx;
  } cell_cmd_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } fsm_state_t;

endpackage

`default_nettype wire

// File: design/pls_req_if.sv
// ---------------------------------------------------------------------------
// pls_req_if
// request channel of the list store: action, value and position
// ---------------------------------------------------------------------------
`default_nettype none

interface pls_req_if;
  logic                                valid;
  logic                                ready;
  logic        [pls_pkg::ACTION_W-1:0] action;
  logic signed [pls_pkg::VALUE_W-1:0]  value;
  logic        [pls_pkg::POS_W-1:0]    position;

  modport source (output valid, action, value, position, input ready);
  modport sink   (input valid, action, value, position, output ready);
endinterface

`default_nettype wire

// File: design/pls_rsp_if.sv
// ---------------------------------------------------------------------------
// pls_rsp_if
// result channel of the list store: status, element, length and last
// ---------------------------------------------------------------------------
`default_nettype none

interface pls_rsp_if;
  logic                                valid;
  logic                                ready;
  logic        [pls_pkg::STATUS_W-1:0] status;
  logic signed [pls_pkg::VALUE_W-1:0]  element;
  logic        [pls_pkg::LENGTH_W-1:0] length;
  logic                                last;

  modport source (output valid, status, element, length, last, input ready);
  modport sink   (input valid, status, element, length, last, output ready);
endinterface

`default_nettype wire

// File: design/pls_cell.sv
// ---------------------------------------------------------------------------
// pls_cell
// one list slot: keeps its value or takes it from a neighbor or the fill bus
// ---------------------------------------------------------------------------
`default_nettype none

module pls_cell #(
  parameter int INDEX = 0
) (
  input  wire logic                               clk,
  input  wire pls_pkg::cell_cmd_t                 cmd,
  input  wire logic signed [pls_pkg::VALUE_W-1:0] fill,
  input  wire logic signed [pls_pkg::VALUE_W-1:0] left,
  input  wire logic signed [pls_pkg::VALUE_W-1:0] right,
  output logic signed      [pls_pkg::VALUE_W-1:0] data
);

  localparam logic [pls_pkg::IDX_W-1:0] HERE = pls_pkg::IDX_W'(INDEX);

  logic signed [pls_pkg::VALUE_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (cmd.kind)
      pls_pkg::CMD_INSERT: begin
        // open a gap at idx, everything behind moves one slot back
        if (HERE > cmd.idx) begin
          data_next = left;
        end else if (HERE == cmd.idx) begin
          data_next = fill;
        end
      end
      pls_pkg::CMD_DELETE: begin
        // close the gap at idx
        if (HERE >= cmd.idx) begin
          data_next = right;
        end
      end
      pls_pkg::CMD_ROTATE: begin
        // head wraps around to the tail slot at idx
        if (HERE == cmd.idx) begin
          data_next = fill;
        end else if (HERE < cmd.idx) begin
          data_next = right;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

// File: design/positional_list_store.sv
// ---------------------------------------------------------------------------
// positional_list_store
// bounded ordered list of signed 32-bit values held in a chain of cells
// ---------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, cell 0 holding the head, so
// stored order is always list order. Insert and delete requests shift every
// cell behind the affected slot by one place and produce one result
// transaction. A dump of n elements produces n results, last marked: in each
// cycle with a free output slot the head cell goes out and the chain
// rotates by one cell, so after n rotations the list is back in place. A
// dump of an empty list gives one result with status list empty. Insert,
// delete and empty dump leave the store ready for the next request; a dump
// of two or more elements takes no request until its last result is loaded.
// Results sit in an output register; a new request is accepted while the
// last result waits, as long as the consumer takes it in the same cycle.
// Cells have no reset: only slots below the count are ever read.
// ---------------------------------------------------------------------------
`default_nettype none

module positional_list_store #(
  parameter int CAPACITY = pls_pkg::CAPACITY_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  pls_req_if.sink   req,
  pls_rsp_if.source rsp
);

  // count has to hold CAPACITY itself
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int VW = pls_pkg::VALUE_W;
  localparam int IW = pls_pkg::IDX_W;
  localparam int PW = pls_pkg::POS_W + 1;

  // list state
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic signed [VW-1:0] cell_q [CAPACITY];

  // dump sequencing
  pls_pkg::fsm_state_t state;
  pls_pkg::fsm_state_t state_next;
  logic [CW-1:0] rem;
  logic [CW-1:0] rem_next;

  // output register
  logic                            out_valid;
  pls_pkg::status_t                out_status;
  logic signed [VW-1:0]            out_element;
  logic [pls_pkg::LENGTH_W-1:0]    out_length;
  logic                            out_last;

  // result being formed this cycle
  logic                 load_out;
  pls_pkg::status_t     res_status;
  logic signed [VW-1:0] res_element;
  logic                 res_last;

  // chain control
  pls_pkg::cell_cmd_t   cmd;
  logic signed [VW-1:0] fill;

  logic out_free;
  logic accept;
  logic full;
  logic empty;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_ext;
  logic [IW-1:0] pos_idx;
  logic [IW-1:0] tail_idx;
  logic [IW-1:0] end_idx;

  // ---- handshake ----
  // output slot is free when empty or drained in this cycle
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == pls_pkg::S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;

  // ---- list conditions ----
  assign full     = (count == CW'(CAPACITY));
  assign empty    = (count == '0);
  assign pos_ext  = {1'b0, req.position};
  assign cnt_ext  = PW'(count);
  // only used where the position is known to lie in the list or one past its end
  assign pos_idx  = IW'(req.position - pls_pkg::POS_W'(1));
  assign end_idx  = IW'(count);
  assign tail_idx = IW'(count - CW'(1));

  // ---- next state ----
  always_comb begin
    state_next = state;
    case (state)
      pls_pkg::S_IDLE: begin
        // a dump of two or more elements keeps streaming after this cycle
        if (accept && (pls_pkg::action_t'(req.action) == pls_pkg::ACT_DUMP)
            && (count > CW'(1))) begin
          state_next = pls_pkg::S_DUMP;
        end
      end
      pls_pkg::S_DUMP: begin
        if (out_free && (rem == CW'(1))) begin
          state_next = pls_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pls_pkg::S_IDLE;
      end
    endcase
  end

  // ---- decode and result ----
  always_comb begin
    load_out    = 1'b0;
    res_status  = pls_pkg::ST_OK;
    res_element = '0;
    res_last    = 1'b1;
    cmd.kind    = pls_pkg::CMD_HOLD;
    cmd.idx     = '0;
    fill        = req.value;
    count_next  = count;
    rem_next    = rem;
    case (state)
      pls_pkg::S_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          case (pls_pkg::action_t'(req.action))
            pls_pkg::ACT_INS_FRONT: begin
              if (full) begin
                res_status = pls_pkg::ST_FULL;
              end else begin
                cmd.kind   = pls_pkg::CMD_INSERT;
                cmd.idx    = '0;
                count_next = count + CW'(1);
              end
            end
            pls_pkg::ACT_INS_END: begin
              if (full) begin
                res_status = pls_pkg::ST_FULL;
              end else begin
                cmd.kind   = pls_pkg::CMD_INSERT;
                cmd.idx    = end_idx;
                count_next = count + CW'(1);
              end
            end
            pls_pkg::ACT_INS_POS: begin
              if (req.position == '0) begin
                res_status = pls_pkg::ST_BADPOS;
              end else if (full) begin
                res_status = pls_pkg::ST_FULL;
              end else if (pos_ext <= cnt_ext + PW'(1)) begin
                cmd.kind   = pls_pkg::CMD_INSERT;
                cmd.idx    = pos_idx;
                count_next = count + CW'(1);
              end else begin
                // beyond the end: append and say so
                cmd.kind   = pls_pkg::CMD_INSERT;
                cmd.idx    = end_idx;
                count_next = count + CW'(1);
                res_status = pls_pkg::ST_APPENDED;
              end
            end
            pls_pkg::ACT_DEL_FRONT: begin
              if (empty) begin
                res_status = pls_pkg::ST_EMPTY;
              end else begin
                cmd.kind   = pls_pkg::CMD_DELETE;
                cmd.idx    = '0;
                count_next = count - CW'(1);
              end
            end
            pls_pkg::ACT_DEL_END: begin
              if (empty) begin
                res_status = pls_pkg::ST_EMPTY;
              end else begin
                cmd.kind   = pls_pkg::CMD_DELETE;
                cmd.idx    = tail_idx;
                count_next = count - CW'(1);
              end
            end
            pls_pkg::ACT_DEL_POS: begin
              // empty list is reported before the position is looked at
              if (empty) begin
                res_status = pls_pkg::ST_EMPTY;
              end else if (req.position == '0) begin
                res_status = pls_pkg::ST_BADPOS;
              end else if (pos_ext > cnt_ext) begin
                res_status = pls_pkg::ST_NOPOS;
              end else begin
                cmd.kind   = pls_pkg::CMD_DELETE;
                cmd.idx    = pos_idx;
                count_next = count - CW'(1);
              end
            end
            pls_pkg::ACT_DUMP: begin
              if (empty) begin
                res_status = pls_pkg::ST_EMPTY;
              end else begin
                // head goes out now, the rest follows from the dump state
                res_element = cell_q[0];
                res_last    = (count == CW'(1));
                cmd.kind    = pls_pkg::CMD_ROTATE;
                cmd.idx     = tail_idx;
                fill        = cell_q[0];
                rem_next    = count - CW'(1);
              end
            end
            default: begin
              // unused action code: plain ok, list untouched
              res_status = pls_pkg::ST_OK;
            end
          endcase
        end
      end
      pls_pkg::S_DUMP: begin
        if (out_free) begin
          load_out    = 1'b1;
          res_element = cell_q[0];
          res_last    = (rem == CW'(1));
          cmd.kind    = pls_pkg::CMD_ROTATE;
          cmd.idx     = tail_idx;
          fill        = cell_q[0];
          rem_next    = rem - CW'(1);
        end
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  // ---- chain of cells ----
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VW-1:0] left;
    logic signed [VW-1:0] right;

    // the ends see themselves; the head's left is never selected, the tail's right only on a delete
    if (i == 0) begin : g_head
      assign left = cell_q[i];
    end else begin : g_body_l
      assign left = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right = cell_q[i];
    end else begin : g_body_r
      assign right = cell_q[i+1];
    end

    pls_cell #(
      .INDEX (i)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .fill  (fill),
      .left  (left),
      .right (right),
      .data  (cell_q[i])
    );
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pls_pkg::S_IDLE;
      count     <= '0;
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rem   <= rem_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---- result payload ----
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status  <= res_status;
      out_element <= res_element;
      out_length  <= pls_pkg::LENGTH_W'(count_next);
      out_last    <= res_last;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.status  = out_status;
  assign rsp.element = out_element;
  assign rsp.length  = out_length;
  assign rsp.last    = out_last;

endmodule

`default_nettype wire

// File: design/pls_checker.sv
// ---------------------------------------------------------------------------
// pls_checker
// port-level checks of the list store, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "positional_list_store_assert.svh"

module pls_checker #(
  parameter int CAPACITY = pls_pkg::CAPACITY_DEFAULT
) (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               req_valid,
  input wire logic                               req_ready,
  input wire logic                               rsp_valid,
  input wire logic                               rsp_ready,
  input wire logic        [pls_pkg::STATUS_W-1:0] rsp_status,
  input wire logic signed [pls_pkg::VALUE_W-1:0]  rsp_element,
  input wire logic        [pls_pkg::LENGTH_W-1:0] rsp_length,
  input wire logic                               rsp_last
);

  // a stalled result keeps its payload
  `PLS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_element) && $stable(rsp_length) && $stable(rsp_last), "stalled result changed")

  // only dump results carry an element
  `PLS_ASSERT_NOW(a_element_ok, rsp_valid && (rsp_element != '0), rsp_status == pls_pkg::ST_OK, "element on a non-ok result")

  // no request is taken while a dump is still streaming
  `PLS_ASSERT_NOW(a_dump_blocks, rsp_valid && !rsp_last, !(req_valid && req_ready), "request taken in mid-dump")

  // an insert refused with status full means the list is at capacity
  `PLS_ASSERT_NOW(a_full_len, rsp_valid && (rsp_status == pls_pkg::ST_FULL), rsp_length == pls_pkg::LENGTH_W'(CAPACITY), "full status with wrong length")

endmodule

bind positional_list_store pls_checker #(
  .CAPACITY (CAPACITY)
) u_pls_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_status  (rsp.status),
  .rsp_element (rsp.element),
  .rsp_length  (rsp.length),
  .rsp_last    (rsp.last)
);

`default_nettype wire
